### rtl/mla_pkg.sv
// ----------------------------------------------------------------------------
// mla_pkg
// Shared types and constants for the multiprecision limb ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package mla_pkg;

  // Port field widths
  localparam int FIELD_BITS = 32;
  localparam int KIND_BITS  = 2;

  // Default limb width and queue depth between front and back
  localparam int LIMB_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Operation codes on in_kind
  localparam logic [KIND_BITS-1:0] KIND_ADD = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_SUB = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_SCA = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_MAC = 2'd3;

  // Decoded operation, one-hot
  typedef struct packed {
    logic mac;
    logic sca;
    logic sub;
    logic add;
  } op_t;

endpackage

`default_nettype wire

### rtl/multiprecision_limb_alu.sv
// Path from input beat to result beat: front register, queue slot, partial
//   products, combine, carry/output.
// Throughput: one limb per cycle while out_ready holds; the carry stage adds onto
//   the running carry, and the multiply is split over two pipeline stages.
// Reset: synchronous, active-low rst_n clears all valids, the queue, the
//   running carry and the in-run flag; payload registers are not reset.
// ----------------------------------------------------------------------------
// multiprecision_limb_alu
// Limb-serial add / subtract / signed-scalar add / multiply-accumulate unit.
// ----------------------------------------------------------------------------
`default_nettype none

module multiprecision_limb_alu #(
  parameter int LIMB_BITS   = mla_pkg::LIMB_BITS_DEF,
  parameter int QUEUE_DEPTH = mla_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input beats: one limb each, least significant first
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mla_pkg::KIND_BITS-1:0]   in_kind,
  input  wire logic [mla_pkg::FIELD_BITS-1:0]  in_dest_limb,
  input  wire logic [mla_pkg::FIELD_BITS-1:0]  in_operand,
  input  wire logic [mla_pkg::FIELD_BITS-1:0]  in_multiplier,
  input  wire logic                            in_last_limb,
  // result beats: one per input beat, in order
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [mla_pkg::FIELD_BITS-1:0]       out_result_limb,
  output logic [mla_pkg::FIELD_BITS-1:0]       out_final_carry,
  output logic                                 out_run_done
);

  // queue item: {op, last, dest, operand, multiplier}
  localparam int ITEM_W = $bits(mla_pkg::op_t) + 1 + 3 * LIMB_BITS;

  logic                 f_valid, f_ready;
  mla_pkg::op_t         f_op;
  logic                 f_last;
  logic [LIMB_BITS-1:0] f_dest, f_opnd, f_mult;
  logic [ITEM_W-1:0]    f_item;

  logic                 q_valid, q_ready;
  logic [ITEM_W-1:0]    q_item;

  // Front: registers the beat and decodes the kind code.
  mla_front #(
    .LIMB_BITS (LIMB_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_dest_limb  (in_dest_limb),
    .in_operand    (in_operand),
    .in_multiplier (in_multiplier),
    .in_last_limb  (in_last_limb),
    .f_valid       (f_valid),
    .f_ready       (f_ready),
    .f_op          (f_op),
    .f_last        (f_last),
    .f_dest        (f_dest),
    .f_opnd        (f_opnd),
    .f_mult        (f_mult)
  );

  assign f_item = {f_op, f_last, f_dest, f_opnd, f_mult};

  // Queue: lets the front keep taking beats while the back is stalled.
  mla_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ITEM_W (ITEM_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  // Back: multiply stages, then the carry stage feeding the output register.
  // The running carry and in-run flag live there and update as each limb's
  // result is loaded, so limbs see the carry strictly in arrival order.
  mla_back #(
    .LIMB_BITS (LIMB_BITS),
    .ITEM_W    (ITEM_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_data          (q_item),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_limb (out_result_limb),
    .out_final_carry (out_final_carry),
    .out_run_done    (out_run_done)
  );

endmodule

`default_nettype wire

### rtl/mla_front.sv
// ----------------------------------------------------------------------------
// mla_front
// Input register slice; decodes the kind code into a one-hot operation.
// ----------------------------------------------------------------------------
`default_nettype none

module mla_front #(
  parameter int LIMB_BITS = mla_pkg::LIMB_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [mla_pkg::KIND_BITS-1:0]    in_kind,
  input  wire logic [mla_pkg::FIELD_BITS-1:0]   in_dest_limb,
  input  wire logic [mla_pkg::FIELD_BITS-1:0]   in_operand,
  input  wire logic [mla_pkg::FIELD_BITS-1:0]   in_multiplier,
  input  wire logic                             in_last_limb,
  output logic                                  f_valid,
  input  wire logic                             f_ready,
  output mla_pkg::op_t                          f_op,
  output logic                                  f_last,
  output logic [LIMB_BITS-1:0]                  f_dest,
  output logic [LIMB_BITS-1:0]                  f_opnd,
  output logic [LIMB_BITS-1:0]                  f_mult
);

  logic                 f_v_r, f_v_nxt;
  mla_pkg::op_t         f_op_r, f_op_nxt;
  logic                 f_last_r;
  logic [LIMB_BITS-1:0] f_dest_r, f_opnd_r, f_mult_r;
  logic                 in_acc;

  assign in_ready = !f_v_r || f_ready;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    f_op_nxt = '0;
    unique case (in_kind)
      mla_pkg::KIND_ADD: f_op_nxt.add = 1'b1;
      mla_pkg::KIND_SUB: f_op_nxt.sub = 1'b1;
      mla_pkg::KIND_SCA: f_op_nxt.sca = 1'b1;
      mla_pkg::KIND_MAC: f_op_nxt.mac = 1'b1;
    endcase
  end

  always_comb begin
    f_v_nxt = f_v_r;
    if (in_acc) begin
      f_v_nxt = 1'b1;
    end else if (f_ready) begin
      f_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else begin
      f_v_r <= f_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_op_r   <= f_op_nxt;
      f_last_r <= in_last_limb;
      f_dest_r <= LIMB_BITS'(in_dest_limb);
      f_opnd_r <= LIMB_BITS'(in_operand);
      f_mult_r <= LIMB_BITS'(in_multiplier);
    end
  end

  assign f_valid = f_v_r;
  assign f_op    = f_op_r;
  assign f_last  = f_last_r;
  assign f_dest  = f_dest_r;
  assign f_opnd  = f_opnd_r;
  assign f_mult  = f_mult_r;

endmodule

`default_nettype wire

### rtl/mla_queue.sv
// ----------------------------------------------------------------------------
// mla_queue
// Small FIFO decoupling the decode front from the execute back.
// ----------------------------------------------------------------------------
`default_nettype none

module mla_queue #(
  parameter int DEPTH  = mla_pkg::QUEUE_DEPTH_DEF,
  parameter int ITEM_W = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire logic [ITEM_W-1:0] wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output logic [ITEM_W-1:0]      rd_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [ITEM_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  // occupancy never runs past the slot count
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

### rtl/mla_back.sv
// ----------------------------------------------------------------------------
// mla_back
// Execute pipeline: partial products, product combine, carry stage + output.
// ----------------------------------------------------------------------------
`default_nettype none

module mla_back #(
  parameter int LIMB_BITS = mla_pkg::LIMB_BITS_DEF,
  parameter int ITEM_W    = $bits(mla_pkg::op_t) + 1 + 3 * LIMB_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire logic [ITEM_W-1:0]              q_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mla_pkg::FIELD_BITS-1:0]      out_result_limb,
  output logic [mla_pkg::FIELD_BITS-1:0]      out_final_carry,
  output logic                                out_run_done
);

  localparam int L     = LIMB_BITS;
  localparam int H     = (L + 1) / 2;   // half-limb for partial products
  localparam int P     = 2 * H;
  localparam int FW    = 2 * P;
  localparam int TW    = L + 2;
  localparam int DW    = L + 1;
  localparam int OUT_W = mla_pkg::FIELD_BITS;

  // unpack queue item
  mla_pkg::op_t q_op;
  logic         q_last;
  logic [L-1:0] q_dest, q_opnd, q_mult;

  assign q_mult = q_data[L-1:0];
  assign q_opnd = q_data[2*L-1:L];
  assign q_dest = q_data[3*L-1:2*L];
  assign q_last = q_data[3*L];
  assign q_op   = mla_pkg::op_t'(q_data[ITEM_W-1:3*L+1]);

  // ---- stage A: partial products
  logic         a_v_r, a_v_nxt, a_ready, a_load;
  mla_pkg::op_t a_op_r;
  logic         a_last_r;
  logic [L-1:0] a_dest_r, a_opnd_r;
  logic [P-1:0] a_ll_r, a_lh_r, a_hl_r, a_hh_r;
  logic [H-1:0] o_lo, o_hi, m_lo, m_hi;

  // ---- stage B: combined product / difference
  logic         b_v_r, b_v_nxt, b_ready, b_load;
  mla_pkg::op_t b_op_r;
  logic         b_last_r, b_c1_r;
  logic [L-1:0] b_base_r, b_lo_r, b_hi_r;
  logic [FW-1:0] prod;
  logic [DW-1:0] diff;

  // ---- output stage with carry update
  logic         o_v_r, o_v_nxt, o_ready, o_load;
  logic [L-1:0] o_res_r, o_fc_r;
  logic         o_done_r;
  logic [L-1:0] rc_r;
  logic         in_run_r;
  logic [L-1:0] sc, add_x, add_y, res, nxt;
  logic [TW-1:0] t;
  logic [DW-1:0] s2;

  assign o_ready = !o_v_r || out_ready;
  assign b_ready = !b_v_r || o_ready;
  assign a_ready = !a_v_r || b_ready;
  assign q_ready = a_ready;
  assign a_load  = q_valid && a_ready;
  assign b_load  = a_v_r && b_ready;
  assign o_load  = b_v_r && o_ready;

  assign o_lo = q_opnd[H-1:0];
  assign o_hi = H'(q_opnd >> H);
  assign m_lo = q_mult[H-1:0];
  assign m_hi = H'(q_mult >> H);

  always_comb begin
    a_v_nxt = a_v_r;
    if (a_load) begin
      a_v_nxt = 1'b1;
    end else if (b_load) begin
      a_v_nxt = 1'b0;
    end
    b_v_nxt = b_v_r;
    if (b_load) begin
      b_v_nxt = 1'b1;
    end else if (o_load) begin
      b_v_nxt = 1'b0;
    end
    o_v_nxt = o_v_r;
    if (o_load) begin
      o_v_nxt = 1'b1;
    end else if (out_ready) begin
      o_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_op_r   <= q_op;
      a_last_r <= q_last;
      a_dest_r <= q_dest;
      a_opnd_r <= q_opnd;
      a_ll_r   <= P'(o_lo) * P'(m_lo);
      a_lh_r   <= P'(o_lo) * P'(m_hi);
      a_hl_r   <= P'(o_hi) * P'(m_lo);
      a_hh_r   <= P'(o_hi) * P'(m_hi);
    end
  end

  assign prod = FW'(a_ll_r) + (FW'(a_lh_r) << H) + (FW'(a_hl_r) << H) + (FW'(a_hh_r) << P);
  assign diff = DW'(a_dest_r) - DW'(a_opnd_r);

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_op_r   <= a_op_r;
      b_last_r <= a_last_r;
      b_base_r <= a_op_r.sub ? diff[L-1:0] : a_dest_r;
      b_c1_r   <= diff[L];
      b_lo_r   <= a_op_r.mac ? prod[L-1:0] : a_opnd_r;
      b_hi_r   <= prod[2*L-1:L];
    end
  end

  // carry stage: the only logic that depends on the previous limb
  assign sc = in_run_r ? rc_r : b_lo_r;

  always_comb begin
    add_x = b_lo_r;
    add_y = '0;
    if (b_op_r.sca) begin
      add_x = sc;
    end
    if (b_op_r.mac) begin
      add_y = rc_r;
    end else if (b_op_r.add) begin
      add_y = L'(rc_r[0]);
    end
  end

  assign t  = TW'(b_base_r) + TW'(add_x) + TW'(add_y);
  assign s2 = DW'(b_base_r) - DW'(rc_r[0]);

  always_comb begin
    res = t[L-1:0];
    nxt = L'(t[L+1:L]);
    unique case (1'b1)
      b_op_r.add: begin
        res = t[L-1:0];
        nxt = L'(t[L+1:L]);
      end
      b_op_r.sub: begin
        res = s2[L-1:0];
        nxt = L'(b_c1_r) + L'(s2[L]);
      end
      b_op_r.sca: begin
        res = t[L-1:0];
        nxt = {L{sc[L-1]}} + L'(t[L]);
      end
      b_op_r.mac: begin
        res = t[L-1:0];
        nxt = b_hi_r + L'(t[L+1:L]);
      end
      default: begin
        res = t[L-1:0];
        nxt = L'(t[L+1:L]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r    <= 1'b0;
      b_v_r    <= 1'b0;
      o_v_r    <= 1'b0;
      rc_r     <= '0;
      in_run_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
      if (o_load) begin
        rc_r     <= b_last_r ? '0 : nxt;
        in_run_r <= !b_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_res_r  <= res;
      o_fc_r   <= b_last_r ? nxt : '0;
      o_done_r <= b_last_r;
    end
  end

  assign out_valid       = o_v_r;
  assign out_result_limb = OUT_W'(o_res_r);
  assign out_final_carry = OUT_W'(o_fc_r);
  assign out_run_done    = o_done_r;

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (o_load && b_last_r) |=> (rc_r == '0 && !in_run_r))
    else $error("running carry not cleared after last limb");

  a_fc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_done) |-> (out_final_carry == '0))
    else $error("final carry set on a limb that is not last");

  a_op_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> $onehot(b_op_r))
    else $error("operation not one-hot in carry stage");

endmodule

`default_nettype wire
